[rtl/core/windowed_event_rate_meter_assert.svh]
// Assertion macros shared by the rate meter RTL.
`ifndef WINDOWED_EVENT_RATE_METER_ASSERT_SVH
`define WINDOWED_EVENT_RATE_METER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define WERM_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rate meter assertion failed");

// Next-cycle implication, disabled while reset is high.
`define WERM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rate meter assertion failed");

`endif

[rtl/core/werm_pkg.sv]
// Package with the constants and types of the windowed event rate meter.
package werm_pkg;

   localparam int HISTORY_DEPTH = 32;
   localparam int TIME_W        = 48;
   localparam int COUNT_W       = 32;
   localparam int DELTA_W       = 33;
   localparam int CFG_W         = 24;
   localparam int RATE_W        = 48;
   localparam int MAG_W         = DELTA_W + $clog2(HISTORY_DEPTH);
   localparam int CSR_ADDR_W    = 3;
   localparam int CSR_DATA_W    = 32;

   localparam logic [CFG_W-1:0] MIN_INTERVAL_RESET = 24'd100000;
   localparam logic [CFG_W-1:0] TICKS_RESET        = 24'd1000000;

   typedef enum logic {
      REG_MIN_INTERVAL     = 1'b0,
      REG_TICKS_PER_SECOND = 1'b1
   } werm_reg_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_CALC,
      ST_OUT
   } werm_state_type;

   typedef enum logic [1:0] {
      MD_IDLE,
      MD_MUL,
      MD_DIV,
      MD_DONE
   } werm_md_state_type;

endpackage

[rtl/core/werm_req_if.sv]
// Input item channel of the rate meter: timestamp and counter reading.
interface werm_req_if;
   logic                           valid;
   logic                           ready;
   logic [werm_pkg::TIME_W-1:0]    time_us;
   logic [werm_pkg::COUNT_W-1:0]   count_value;

   modport source (output valid, output time_us, output count_value, input ready);
   modport sink   (input valid, input time_us, input count_value, output ready);
endinterface

[rtl/core/werm_rsp_if.sv]
// Result item channel of the rate meter: rate, rate valid flag and ring fill.
interface werm_rsp_if #(
   parameter int HISTORY_DEPTH = werm_pkg::HISTORY_DEPTH
);
   localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);

   logic                                valid;
   logic                                ready;
   logic signed [werm_pkg::RATE_W-1:0]  rate;
   logic                                rate_valid;
   logic [FILL_W-1:0]                   history_fill;

   modport source (output valid, output rate, output rate_valid, output history_fill,
                   input ready);
   modport sink   (input valid, input rate, input rate_valid, input history_fill,
                   output ready);
endinterface

[rtl/core/werm_muldiv.sv]
// Bit-serial multiply by ticks per second, restoring divide by the span, and saturation.
module werm_muldiv #(
   parameter int MAG_W = werm_pkg::MAG_W
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic                                neg,
   input  logic [MAG_W-1:0]                    mag,
   input  logic [werm_pkg::CFG_W-1:0]          tps,
   input  logic [werm_pkg::TIME_W-1:0]         span,
   output logic                                done,
   output logic signed [werm_pkg::RATE_W-1:0]  rate
);
   localparam int CfgW  = werm_pkg::CFG_W;
   localparam int TimeW = werm_pkg::TIME_W;
   localparam int RateW = werm_pkg::RATE_W;
   localparam int ProdW = MAG_W + CfgW;
   localparam int CntW  = $clog2(ProdW + 1);
   localparam logic [CntW-1:0] MulLast = CntW'(CfgW - 1);
   localparam logic [CntW-1:0] DivLast = CntW'(ProdW - 1);
   localparam logic [RateW-1:0] RateMax = {1'b0, {(RateW-1){1'b1}}};
   localparam logic [RateW-1:0] RateMin = {1'b1, {(RateW-1){1'b0}}};

   werm_pkg::werm_md_state_type state_ff, state_in;

   logic [CntW-1:0]  cnt_ff;
   logic [ProdW-1:0] acc_ff;
   logic [ProdW-1:0] mcand_ff;
   logic [CfgW-1:0]  mult_ff;
   logic [TimeW-1:0] rem_ff;
   logic [TimeW-1:0] span_ff;
   logic             neg_ff;

   logic [TimeW:0]   rem_sh;
   logic [TimeW:0]   rem_sub;
   logic             rem_ge;
   logic             hi_nz;
   logic             sat;
   logic [RateW-1:0] mag_out;

   assign rem_sh  = {rem_ff, acc_ff[ProdW-1]};
   assign rem_sub = rem_sh - {1'b0, span_ff};
   assign rem_ge  = rem_sh >= {1'b0, span_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= werm_pkg::MD_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      done     = 1'b0;
      unique case (state_ff)
         werm_pkg::MD_IDLE: begin
            if (start) begin
               state_in = werm_pkg::MD_MUL;
            end
         end
         werm_pkg::MD_MUL: begin
            if (cnt_ff == MulLast) begin
               state_in = werm_pkg::MD_DIV;
            end
         end
         werm_pkg::MD_DIV: begin
            if (cnt_ff == DivLast) begin
               state_in = werm_pkg::MD_DONE;
            end
         end
         werm_pkg::MD_DONE: begin
            done     = 1'b1;
            state_in = werm_pkg::MD_IDLE;
         end
         default: begin
            state_in = werm_pkg::MD_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         werm_pkg::MD_IDLE: begin
            if (start) begin
               cnt_ff   <= '0;
               acc_ff   <= '0;
               mcand_ff <= {{CfgW{1'b0}}, mag};
               mult_ff  <= tps;
               span_ff  <= span;
               neg_ff   <= neg;
            end
         end
         werm_pkg::MD_MUL: begin
            if (mult_ff[0]) begin
               acc_ff <= acc_ff + mcand_ff;
            end
            mcand_ff <= {mcand_ff[ProdW-2:0], 1'b0};
            mult_ff  <= {1'b0, mult_ff[CfgW-1:1]};
            if (cnt_ff == MulLast) begin
               cnt_ff <= '0;
               rem_ff <= '0;
            end else begin
               cnt_ff <= cnt_ff + 1'b1;
            end
         end
         werm_pkg::MD_DIV: begin
            rem_ff <= rem_ge ? rem_sub[TimeW-1:0] : rem_sh[TimeW-1:0];
            acc_ff <= {acc_ff[ProdW-2:0], rem_ge};
            cnt_ff <= cnt_ff + 1'b1;
         end
         default: begin
         end
      endcase
   end

   // The quotient in acc_ff is a magnitude; clamp it before applying the sign.
   always_comb begin
      hi_nz = |acc_ff[ProdW-1:RateW];
      if (neg_ff) begin
         sat     = hi_nz || (acc_ff[RateW-1] && (|acc_ff[RateW-2:0]));
         mag_out = sat ? RateMin : acc_ff[RateW-1:0];
         rate    = $signed(~mag_out + 1'b1);
      end else begin
         sat     = hi_nz || acc_ff[RateW-1];
         mag_out = sat ? RateMax : acc_ff[RateW-1:0];
         rate    = $signed(mag_out);
      end
   end

endmodule

[rtl/core/windowed_event_rate_meter.sv]
// Top level of the windowed event rate meter.
//
// Each item on req_ch carries a microsecond timestamp and a counter reading.
// When the time since the last kept sample exceeds min_interval_us, the count
// change and timestamp enter a ring of HISTORY_DEPTH entries. Every item
// produces exactly one result item on rsp_ch: the summed count change times
// ticks_per_second divided by the span of kept timestamps, saturated to 48
// bits signed, with rate_valid low and rate zero when the span is zero.
// The CSR port sets min_interval_us (address 0) and ticks_per_second (address 4).
// One item is processed at a time. The ring is scanned through its single read
// port, followed by a bit-serial multiply, a bit-serial divide and a done state;
// the result is then offered, and the next item can be accepted once the result
// is loaded into the output register. When the span is zero, including with an
// empty ring, the multiply and divide are skipped and the result is offered
// straight after the scan.
// The result sits in an output register, so a stalled receiver delays only
// the next result, not the acceptance of the next item.
// Synchronous reset clears the configuration to its defaults, empties the
// ring and drops any pending result; ring contents are never read unwritten.
`include "windowed_event_rate_meter_assert.svh"

module windowed_event_rate_meter #(
   parameter int HISTORY_DEPTH = werm_pkg::HISTORY_DEPTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   werm_req_if.sink                             req_ch,
   werm_rsp_if.source                           rsp_ch,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [werm_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [werm_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [werm_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready
);
   localparam int PosW   = $clog2(HISTORY_DEPTH);
   localparam int FillW  = $clog2(HISTORY_DEPTH + 1);
   localparam int DeltaW = werm_pkg::DELTA_W;
   localparam int TimeW  = werm_pkg::TIME_W;
   localparam int CountW = werm_pkg::COUNT_W;
   localparam int CfgW   = werm_pkg::CFG_W;
   localparam int RateW  = werm_pkg::RATE_W;
   localparam int SumW   = DeltaW + $clog2(HISTORY_DEPTH);
   localparam int EntryW = TimeW + DeltaW;
   localparam int PadW   = werm_pkg::CSR_DATA_W - CfgW;
   localparam logic [PosW-1:0]  LastPos  = PosW'(HISTORY_DEPTH - 1);
   localparam logic [FillW-1:0] FullFill = FillW'(HISTORY_DEPTH);

   werm_pkg::werm_state_type state_ff, state_in;

   logic [CfgW-1:0]   min_interval_ff;
   logic [CfgW-1:0]   ticks_ff;
   logic [CountW-1:0] last_count_ff;
   logic [TimeW-1:0]  last_time_ff;
   logic [PosW-1:0]   pos_ff;
   logic [FillW-1:0]  fill_ff;

   logic [EntryW-1:0] ring_mem [HISTORY_DEPTH];
   logic [EntryW-1:0] rd_data_ff;
   logic              rd_pend_ff;
   logic [PosW-1:0]   scan_ptr_ff;
   logic [FillW-1:0]  issued_ff;
   logic [TimeW-1:0]  tmin_ff;
   logic [TimeW-1:0]  tmax_ff;
   logic [SumW-1:0]   sum_ff;

   logic signed [RateW-1:0] res_rate_ff;
   logic                    res_valid_ff;
   logic                    rsp_valid_ff;
   logic signed [RateW-1:0] rsp_rate_ff;
   logic                    rsp_rv_ff;
   logic [FillW-1:0]        rsp_fill_ff;

   logic              req_acc;
   logic              csr_wr;
   logic [TimeW:0]    elapsed;
   logic              kept;
   logic [DeltaW-1:0] delta;
   logic [PosW-1:0]   pos_adv;
   logic              rd_issue;
   logic              scan_end;
   logic              span_nz;
   logic              md_start;
   logic              md_done;
   logic              out_load;
   logic [TimeW-1:0]  span;
   logic [SumW-1:0]   sum_mag;
   logic [TimeW-1:0]  ent_time;
   logic [DeltaW-1:0] ent_delta;
   logic signed [RateW-1:0] md_rate;

   assign req_acc    = req_ch.valid && req_ch.ready;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   assign elapsed = {1'b0, req_ch.time_us} - {1'b0, last_time_ff};
   assign kept    = !elapsed[TimeW] && (elapsed[TimeW-1:0] > {{(TimeW-CfgW){1'b0}}, min_interval_ff});
   assign delta   = {1'b0, req_ch.count_value} - {1'b0, last_count_ff};
   assign pos_adv = (pos_ff == LastPos) ? '0 : pos_ff + 1'b1;

   assign ent_time  = rd_data_ff[EntryW-1:DeltaW];
   assign ent_delta = rd_data_ff[DeltaW-1:0];
   assign span      = tmax_ff - tmin_ff;
   assign span_nz   = (fill_ff != '0) && (tmax_ff != tmin_ff);
   assign sum_mag   = sum_ff[SumW-1] ? (~sum_ff + 1'b1) : sum_ff;

   always_comb begin
      unique case (werm_pkg::werm_reg_type'(csr_paddr[2]))
         werm_pkg::REG_MIN_INTERVAL:     csr_prdata = {{PadW{1'b0}}, min_interval_ff};
         werm_pkg::REG_TICKS_PER_SECOND: csr_prdata = {{PadW{1'b0}}, ticks_ff};
         default:                        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_interval_ff <= werm_pkg::MIN_INTERVAL_RESET;
         ticks_ff        <= werm_pkg::TICKS_RESET;
      end else if (csr_wr) begin
         unique case (werm_pkg::werm_reg_type'(csr_paddr[2]))
            werm_pkg::REG_MIN_INTERVAL:     min_interval_ff <= csr_pwdata[CfgW-1:0];
            werm_pkg::REG_TICKS_PER_SECOND: ticks_ff        <= csr_pwdata[CfgW-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= werm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      rd_issue = 1'b0;
      scan_end = 1'b0;
      md_start = 1'b0;
      out_load = 1'b0;
      unique case (state_ff)
         werm_pkg::ST_IDLE: begin
            if (req_acc) begin
               state_in = werm_pkg::ST_SCAN;
            end
         end
         werm_pkg::ST_SCAN: begin
            rd_issue = (issued_ff != fill_ff);
            if (!rd_issue && !rd_pend_ff) begin
               scan_end = 1'b1;
               if (span_nz) begin
                  md_start = 1'b1;
                  state_in = werm_pkg::ST_CALC;
               end else begin
                  state_in = werm_pkg::ST_OUT;
               end
            end
         end
         werm_pkg::ST_CALC: begin
            if (md_done) begin
               state_in = werm_pkg::ST_OUT;
            end
         end
         werm_pkg::ST_OUT: begin
            out_load = !rsp_valid_ff || rsp_ch.ready;
            if (out_load) begin
               state_in = werm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = werm_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_count_ff <= '0;
         last_time_ff  <= '0;
         pos_ff        <= '0;
         fill_ff       <= '0;
         rd_pend_ff    <= 1'b0;
      end else begin
         rd_pend_ff <= rd_issue;
         if (req_acc && kept) begin
            last_count_ff <= req_ch.count_value;
            last_time_ff  <= req_ch.time_us;
            pos_ff        <= pos_adv;
            if (fill_ff != FullFill) begin
               fill_ff <= fill_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc && kept) begin
         ring_mem[pos_adv] <= {req_ch.time_us, delta};
      end
      if (rd_issue) begin
         rd_data_ff <= ring_mem[scan_ptr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         scan_ptr_ff <= kept ? pos_adv : pos_ff;
         issued_ff   <= '0;
         tmin_ff     <= '1;
         tmax_ff     <= '0;
         sum_ff      <= '0;
      end else begin
         if (rd_issue) begin
            scan_ptr_ff <= (scan_ptr_ff == '0) ? LastPos : scan_ptr_ff - 1'b1;
            issued_ff   <= issued_ff + 1'b1;
         end
         if (rd_pend_ff) begin
            if (ent_time < tmin_ff) begin
               tmin_ff <= ent_time;
            end
            if (ent_time > tmax_ff) begin
               tmax_ff <= ent_time;
            end
            sum_ff <= sum_ff + {{(SumW-DeltaW){ent_delta[DeltaW-1]}}, ent_delta};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (scan_end && !span_nz) begin
         res_rate_ff  <= '0;
         res_valid_ff <= 1'b0;
      end else if (md_done) begin
         res_rate_ff  <= md_rate;
         res_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_rate_ff <= res_rate_ff;
         rsp_rv_ff   <= res_valid_ff;
         rsp_fill_ff <= fill_ff;
      end
   end

   assign req_ch.ready        = (state_ff == werm_pkg::ST_IDLE);
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.rate         = rsp_rate_ff;
   assign rsp_ch.rate_valid   = rsp_rv_ff;
   assign rsp_ch.history_fill = rsp_fill_ff;

   werm_muldiv #(
      .MAG_W (SumW)
   ) u_muldiv (
      .clock (clock),
      .reset (reset),
      .start (md_start),
      .neg   (sum_ff[SumW-1]),
      .mag   (sum_mag),
      .tps   (ticks_ff),
      .span  (span),
      .done  (md_done),
      .rate  (md_rate)
   );

   `WERM_ASSERT_NEXT(a_accept_starts_scan, clock, reset, req_acc, state_ff == werm_pkg::ST_SCAN)
   `WERM_ASSERT_IMPLY(a_fill_never_drops, clock, reset, !$past(reset), fill_ff >= $past(fill_ff))
   `WERM_ASSERT_IMPLY(a_invalid_rate_zero, clock, reset, rsp_valid_ff && !rsp_rv_ff, rsp_rate_ff == '0)

endmodule

[verif/windowed_event_rate_meter_tb.sv]
// Self-checking testbench of the windowed event rate meter with random traffic and checking.
module windowed_event_rate_meter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HISTORY_DEPTH = werm_pkg::HISTORY_DEPTH;
   localparam int TIME_W = werm_pkg::TIME_W;
   localparam int COUNT_W = werm_pkg::COUNT_W;
   localparam int DELTA_W = werm_pkg::DELTA_W;
   localparam int CFG_W = werm_pkg::CFG_W;
   localparam int RATE_W = werm_pkg::RATE_W;
   localparam int CSR_ADDR_W = werm_pkg::CSR_ADDR_W;
   localparam int CSR_DATA_W = werm_pkg::CSR_DATA_W;
   localparam logic [CFG_W-1:0] MIN_INTERVAL_RESET = werm_pkg::MIN_INTERVAL_RESET;
   localparam logic [CFG_W-1:0] TICKS_RESET = werm_pkg::TICKS_RESET;
   localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
   localparam logic [63:0] RATE_MAX = 64'h0000_7FFF_FFFF_FFFF;
   localparam logic [63:0] TIME_CAP = 64'h0000_FF00_0000_0000;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int LONG_HOLD_CYCLES = 1500;

   typedef struct packed {
      logic [TIME_W-1:0]  time_us;
      logic [COUNT_W-1:0] count_value;
   } meter_sample_type;

   typedef struct packed {
      logic signed [RATE_W-1:0] rate;
      logic                     rate_valid;
      logic [FILL_W-1:0]        history_fill;
   } rate_reading_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   werm_req_if req_ch ();
   werm_rsp_if rsp_ch ();

   windowed_event_rate_meter u_top (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Shadow copy of the meter state and its two registers.
   logic [CFG_W-1:0]           cfg_min_gap;
   logic [CFG_W-1:0]           cfg_ticks;
   logic [TIME_W-1:0]          kept_time;
   logic [COUNT_W-1:0]         kept_count;
   int unsigned                ring_head;
   int unsigned                ring_fill;
   logic [TIME_W-1:0]          ring_time [HISTORY_DEPTH];
   logic signed [DELTA_W-1:0]  ring_delta [HISTORY_DEPTH];

   meter_sample_type pending_samples [$];
   rate_reading_type rate_expect [$];

   int n_queued = 0;
   int n_accepted = 0;
   int n_results = 0;
   int n_kept = 0;
   int n_no_span = 0;
   int n_sat_high = 0;
   int n_sat_low = 0;
   int n_settings = 0;
   int mismatches = 0;
   int cycles = 0;

   logic req_fire = 1'b0;
   int burst_left = 1;
   int gap_left = 0;
   int hold_wanted = 0;
   int hold_started = 0;
   int hold_left = 0;
   int stall_window = 0;
   int stall_pct = 0;
   meter_sample_type next_sample;

   logic [TIME_W-1:0]  tnow;
   logic [COUNT_W-1:0] gen_count;
   int phase_no = 0;

   function automatic rate_reading_type predict_reading(input logic [TIME_W-1:0] t,
                                                        input logic [COUNT_W-1:0] c);
      rate_reading_type r;
      longint elapsed;
      logic signed [DELTA_W-1:0] delta;
      logic [TIME_W-1:0] tmin;
      logic [TIME_W-1:0] tmax;
      logic [TIME_W-1:0] span;
      longint sum;
      logic [63:0] mag;
      logic [63:0] q;
      logic [63:0] neg_q;
      int unsigned j;
      int unsigned k;
      r = '0;
      elapsed = longint'({16'd0, t}) - longint'({16'd0, kept_time});
      delta = $signed({1'b0, c}) - $signed({1'b0, kept_count});
      if (elapsed > longint'({40'd0, cfg_min_gap})) begin
         kept_time = t;
         kept_count = c;
         ring_head = (ring_head + 1) % HISTORY_DEPTH;
         if (ring_fill < HISTORY_DEPTH) ring_fill++;
         ring_time[ring_head] = t;
         ring_delta[ring_head] = delta;
         n_kept++;
      end
      span = '0;
      if (ring_fill > 0) begin
         tmin = ring_time[ring_head];
         tmax = tmin;
         sum = 0;
         for (k = 0; k < ring_fill; k++) begin
            j = (ring_head + HISTORY_DEPTH - k) % HISTORY_DEPTH;
            if (ring_time[j] < tmin) tmin = ring_time[j];
            if (ring_time[j] > tmax) tmax = ring_time[j];
            sum += longint'(ring_delta[j]);
         end
         span = tmax - tmin;
         if (span != 0) begin
            mag = (sum < 0) ? -sum : sum;
            q = (mag * {40'd0, cfg_ticks}) / {16'd0, span};
            r.rate_valid = 1'b1;
            if (sum < 0) begin
               if (q > RATE_MAX + 1) begin
                  q = RATE_MAX + 1;
                  n_sat_low++;
               end
               neg_q = 64'd0 - q;
               r.rate = neg_q[RATE_W-1:0];
            end else begin
               if (q > RATE_MAX) begin
                  q = RATE_MAX;
                  n_sat_high++;
               end
               r.rate = q[RATE_W-1:0];
            end
         end
      end
      if (span == 0) n_no_span++;
      r.history_fill = ring_fill[FILL_W-1:0];
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] want,
                                  input logic [63:0] got);
      mismatches++;
      if (mismatches <= 10) $display("mismatch in %s: expected %0h, got %0h", what, want, got);
   endtask

   // Sender: bursts of random length separated by random gaps.
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_fire) begin
         if (gap_left != 0) begin
            req_ch.valid <= 1'b0;
            gap_left--;
         end else if (pending_samples.size() != 0) begin
            next_sample = pending_samples.pop_front();
            req_ch.valid <= 1'b1;
            req_ch.time_us <= next_sample.time_us;
            req_ch.count_value <= next_sample.count_value;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 8);
               case ($urandom_range(19))
                  0, 1, 2, 3, 4, 5, 6, 7: gap_left = 0;
                  8, 9, 10, 11, 12, 13, 14, 15, 16: gap_left = $urandom_range(1, 5);
                  default: gap_left = $urandom_range(10, 200);
               endcase
            end
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Receiver: stall density is redrawn at the start of each stall window, plus an occasional long hold-off.
   always @(negedge clock) begin
      if (hold_started != hold_wanted) begin
         hold_started = hold_wanted;
         hold_left = LONG_HOLD_CYCLES;
      end
      if (stall_window == 0) begin
         stall_window = 64;
         case ($urandom_range(4))
            0, 1: stall_pct = 0;
            2: stall_pct = 30;
            3: stall_pct = 60;
            default: stall_pct = 90;
         endcase
      end
      stall_window--;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left--;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Monitor: predicts on each accepted item and checks each result item.
   always @(posedge clock) begin
      rate_reading_type want;
      req_fire <= req_ch.valid && req_ch.ready && !reset;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            rate_expect.push_back(predict_reading(req_ch.time_us, req_ch.count_value));
            n_accepted++;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            n_results++;
            if (rate_expect.size() == 0) begin
               report_mismatch("unexpected result, rate", 64'd0, {16'd0, rsp_ch.rate});
            end else begin
               want = rate_expect.pop_front();
               if (rsp_ch.rate !== want.rate)
                  report_mismatch("rate", {16'd0, want.rate}, {16'd0, rsp_ch.rate});
               if (rsp_ch.rate_valid !== want.rate_valid)
                  report_mismatch("rate_valid", 64'(want.rate_valid), 64'(rsp_ch.rate_valid));
               if (rsp_ch.history_fill !== want.history_fill)
                  report_mismatch("history_fill", 64'(want.history_fill),
                                  64'(rsp_ch.history_fill));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles with %0d results outstanding", cycles,
                  rate_expect.size());
         $display("FAIL");
         $finish;
      end
   end

   task automatic csr_write(input werm_pkg::werm_reg_type which,
                            input logic [CFG_W-1:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {which, 2'b00};
      csr_pwdata <= {8'($urandom()), value};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (which == werm_pkg::REG_MIN_INTERVAL) cfg_min_gap = value;
      else cfg_ticks = value;
   endtask

   task automatic csr_read_check(input werm_pkg::werm_reg_type which,
                                 input logic [CFG_W-1:0] want);
      logic [CSR_DATA_W-1:0] got;
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= {which, 2'b00};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      got = csr_prdata;
      if (got[CFG_W-1:0] !== want) report_mismatch("register readback", 64'(want), 64'(got));
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic wait_drained();
      while (n_accepted != n_queued || rate_expect.size() != 0) @(posedge clock);
   endtask

   task automatic set_config(input logic [CFG_W-1:0] min_gap, input logic [CFG_W-1:0] ticks);
      wait_drained();
      csr_write(werm_pkg::REG_MIN_INTERVAL, min_gap);
      csr_write(werm_pkg::REG_TICKS_PER_SECOND, ticks);
      csr_read_check(werm_pkg::REG_MIN_INTERVAL, min_gap);
      csr_read_check(werm_pkg::REG_TICKS_PER_SECOND, ticks);
      n_settings++;
      @(posedge clock);
   endtask

   task automatic queue_sample(input logic [TIME_W-1:0] t, input logic [COUNT_W-1:0] c);
      pending_samples.push_back('{time_us: t, count_value: c});
      n_queued++;
   endtask

   // Mostly forward-moving sequences around the minimum interval, with some noise.
   task automatic queue_random_sample();
      int roll;
      logic [63:0] r64;
      logic [63:0] step;
      logic [63:0] wrapped;
      logic [TIME_W-1:0] t;
      logic [COUNT_W-1:0] c;
      roll = $urandom_range(99);
      if (roll < 12) begin
         r64 = {$urandom(), $urandom()};
         wrapped = r64 % ({16'd0, tnow} + 64'd1);
         t = wrapped[TIME_W-1:0];
         c = (roll < 6) ? $urandom() : gen_count;
      end else begin
         case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: begin
               if ($urandom_range(1) == 0) step = cfg_min_gap + 1 + $urandom_range(3);
               else step = cfg_min_gap + 1 + $urandom_range(cfg_min_gap / 2 + 1000);
            end
            6: step = cfg_min_gap;
            7, 8: step = $urandom_range(cfg_min_gap);
            default: step = 0;
         endcase
         if ($urandom_range(49) == 0) step += $urandom();
         if ({16'd0, tnow} + step < TIME_CAP) tnow += step[TIME_W-1:0];
         case ($urandom_range(9))
            0, 1, 2: ;
            3, 4, 5: gen_count += $urandom_range(1000);
            6: gen_count -= $urandom_range(1000);
            7: gen_count += $urandom();
            default: gen_count = $urandom();
         endcase
         t = tnow;
         c = gen_count;
      end
      queue_sample(t, c);
   endtask

   task automatic run_phase(input logic [CFG_W-1:0] min_gap, input logic [CFG_W-1:0] ticks,
                            input int n_items, input bit hold_off);
      logic [63:0] base;
      int i;
      set_config(min_gap, ticks);
      phase_no++;
      base = {$urandom(), $urandom()};
      base = (64'(phase_no) << 45) + {20'd0, base[43:0]};
      if (base > {16'd0, tnow}) tnow = base[TIME_W-1:0];
      if (hold_off) hold_wanted++;
      for (i = 0; i < n_items; i++) queue_random_sample();
   endtask

   initial begin
      reset = 1'b1;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      req_ch.valid = 1'b0;
      req_ch.time_us = '0;
      req_ch.count_value = '0;
      rsp_ch.ready = 1'b0;
      cfg_min_gap = MIN_INTERVAL_RESET;
      cfg_ticks = TICKS_RESET;
      kept_time = '0;
      kept_count = '0;
      ring_head = 0;
      ring_fill = 0;
      for (int k = 0; k < HISTORY_DEPTH; k++) begin
         ring_time[k] = '0;
         ring_delta[k] = '0;
      end
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      csr_read_check(werm_pkg::REG_MIN_INTERVAL, MIN_INTERVAL_RESET);
      csr_read_check(werm_pkg::REG_TICKS_PER_SECOND, TICKS_RESET);

      // No interval at all and the largest scale: tiny spans saturate the rate.
      set_config('0, '1);
      queue_sample(48'd0, 32'd0);
      queue_sample(48'd1, 32'd0);
      queue_sample(48'd2, 32'hFFFF_FFFF);
      queue_sample(48'd2, 32'hFFFF_FFFF);
      queue_sample(48'd1, 32'd5);

      // Default setting: interval boundary, queries, falling counts.
      set_config(MIN_INTERVAL_RESET, TICKS_RESET);
      queue_sample(48'd100002, 32'd7);
      queue_sample(48'd100003, 32'd7);
      queue_sample(48'd250000, 32'd7);
      queue_sample(48'd400000, 32'd2);
      queue_sample(48'd500001, 32'd0);
      queue_sample(48'd600002, 32'hFFFF_FFFF);

      // Largest interval with a scale of one.
      set_config('1, 24'd1);
      queue_sample(48'd600002 + 48'd16777215, 32'd3);
      queue_sample(48'd600002 + 48'd16777216, 32'd3);
      tnow = 48'd600002 + 48'd16777216;
      gen_count = 32'd3;

      run_phase('0, '1, 80, 1'b0);
      run_phase(24'd1, 24'd1, 75, 1'b1);
      run_phase(CFG_W'($urandom_range(5000)), TICKS_RESET, 75, 1'b0);
      run_phase('1, '0, 70, 1'b0);
      run_phase(CFG_W'($urandom()), CFG_W'($urandom_range(1, 24'hFFFFFF)), 75, 1'b0);
      run_phase(MIN_INTERVAL_RESET, CFG_W'($urandom_range(1, 24'hFFFFFF)), 75, 1'b0);
      queue_sample('1, $urandom());

      wait_drained();
      repeat (150) @(posedge clock);

      $display("Ran %0d items and checked %0d results under %0d register settings.",
               n_accepted, n_results, n_settings);
      $display("Samples kept: %0d; no span: %0d; saturated high: %0d, low: %0d.",
               n_kept, n_no_span, n_sat_high, n_sat_low);
      if (mismatches == 0 && rate_expect.size() == 0) begin
         $display("PASS");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatches, rate_expect.size());
         $display("FAIL");
      end
      $finish;
   end

endmodule
